>>> src/hrst_pkg.sv
// hrst_pkg: sizes, codes and types shared by the successor table cells and top level
// depends on nothing
`default_nettype none

package hrst_pkg;

    localparam int MAX_NODES = 64;
    localparam int IDX_W     = $clog2(MAX_NODES);
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int ID_W      = 32;
    localparam int OP_W      = 3;
    localparam int ST_W      = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 3'd0,
        OP_REM   = 3'd1,
        OP_OWNER = 3'd2,
        OP_SUCC  = 3'd3,
        OP_PRED  = 3'd4
    } t_op;

    typedef enum logic [ST_W-1:0] {
        ST_OK         = 3'd0,
        ST_EMPTY      = 3'd1,
        ST_NOT_MEMBER = 3'd2,
        ST_PRESENT    = 3'd3,
        ST_FULL       = 3'd4
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    // per-cell control from the sequencer
    typedef struct packed {
        logic cmp;    // compare stored id against the incoming key
        logic ins;    // insert: shift up from the left neighbor or load key
        logic rem;    // remove: shift down from the right neighbor
        logic pick;   // this cell drives the lookup answer
        logic valid;  // this cell holds a member
    } t_cell_ctl;

endpackage

`default_nettype wire

>>> src/hrst_cell.sv
// hrst_cell: one slot of the sorted row, holds an id and its compare flags
// depends on hrst_pkg
`default_nettype none

module hrst_cell (
    input  wire                        i_clk,
    input  hrst_pkg::t_cell_ctl        i_ctl,
    input  wire [hrst_pkg::ID_W-1:0]   i_cmp_key,
    input  wire [hrst_pkg::ID_W-1:0]   i_ins_key,
    input  wire                        i_left_lt,
    input  wire [hrst_pkg::ID_W-1:0]   i_left_id,
    input  wire [hrst_pkg::ID_W-1:0]   i_right_id,
    output logic [hrst_pkg::ID_W-1:0]  o_id,
    output logic                       o_lt,
    output logic                       o_eq,
    output logic [hrst_pkg::ID_W-1:0]  o_pick_id
);
    import hrst_pkg::*;

    logic [ID_W-1:0] r_id;
    logic            r_lt;
    logic            r_eq;

    always_ff @(posedge i_clk) begin
        if (i_ctl.cmp) begin
            r_lt <= i_ctl.valid && (r_id < i_cmp_key);
            r_eq <= i_ctl.valid && (r_id == i_cmp_key);
        end
        if (i_ctl.ins && !r_lt) begin
            // first slot at or after the key takes it, the rest move up
            r_id <= i_left_lt ? i_ins_key : i_left_id;
        end else if (i_ctl.rem && !r_lt) begin
            r_id <= i_right_id;
        end
    end

    assign o_id      = r_id;
    assign o_lt      = r_lt;
    assign o_eq      = r_eq;
    assign o_pick_id = i_ctl.pick ? r_id : '0;

endmodule

`default_nettype wire

>>> src/hash_ring_successor_table_top.sv
// hash_ring_successor_table_top: sorted ring of node ids built as a row of hrst_cell slots
// depends on hrst_pkg and hrst_cell
`default_nettype none

// channel   | ports                                  | handshake
// ----------+----------------------------------------+---------------------------
// item in   | i_operation, i_key                     | start high while busy low
// result    | o_node_id, o_status                    | o_valid strobe, one cycle
//
// at the accepting edge every cell compares its id with the key and latches its
// flags; in the following cycle the row shifts for an add or remove and the answer
// is picked from the row into the output register
// busy is high in the execute state, so no new item is accepted until the current one is through
// o_valid rises in the cycle after the execute cycle; the receiver cannot stall
// reset clears the node count and sequencer; slot contents are never read unset

module hash_ring_successor_table_top (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    input  wire [hrst_pkg::OP_W-1:0]      i_operation,
    input  wire [hrst_pkg::ID_W-1:0]      i_key,
    output logic                          busy,
    output logic                          o_valid,
    output logic [hrst_pkg::ID_W-1:0]     o_node_id,
    output logic [hrst_pkg::ST_W-1:0]     o_status
);
    import hrst_pkg::*;

    // sequencer
    t_state r_state, n_state;
    logic   accept;

    // item held through the execute cycle
    logic [OP_W-1:0] r_op;
    logic [ID_W-1:0] r_key;
    logic [CNT_W-1:0] r_count, n_count;

    // result register
    logic            r_valid,   n_valid;
    logic [ID_W-1:0] r_node_id, n_node_id;
    logic [ST_W-1:0] r_status,  n_status;

    // row
    t_cell_ctl       ctl     [MAX_NODES];
    logic [ID_W-1:0] cell_id [MAX_NODES];
    logic [ID_W-1:0] pick_id [MAX_NODES];
    logic [MAX_NODES-1:0] lt, eq, valid, last, pick;

    logic do_ins, do_rem;
    logic is_owner, is_succ, is_pred;
    logic empty, full, member, any_ge;
    logic owner_wrap, succ_wrap, pred_wrap;
    logic [ID_W-1:0] picked;

    assign accept = start && (r_state == S_IDLE);
    assign busy   = (r_state == S_EXEC);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_op  <= i_operation;
            r_key <= i_key;
        end
        r_node_id <= n_node_id;
        r_status  <= n_status;
    end

    // slot i holds a member while i is below the count; last marks the top member
    always_comb begin
        for (int i = 0; i < MAX_NODES; i++) begin
            valid[i] = r_count > CNT_W'(i);
        end
        for (int i = 0; i < MAX_NODES - 1; i++) begin
            last[i] = valid[i] && !valid[i+1];
        end
        last[MAX_NODES-1] = valid[MAX_NODES-1];
    end

    assign empty      = (r_count == '0);
    assign full       = (r_count == CNT_W'(MAX_NODES));
    assign member     = |eq;
    assign any_ge     = |(valid & ~lt);
    assign owner_wrap = !any_ge;           // key above every member
    assign succ_wrap  = |(eq & last);      // successor of the top member
    assign pred_wrap  = eq[0];             // predecessor of the lowest member

    assign is_owner = busy && (r_op == OP_OWNER);
    assign is_succ  = busy && (r_op == OP_SUCC);
    assign is_pred  = busy && (r_op == OP_PRED);

    // which slot answers the lookup
    generate
        for (genvar g = 0; g < MAX_NODES; g++) begin : g_pick
            logic first_ge, succ_hit, pred_hit;
            if (g == 0) begin : g_lo
                assign first_ge = valid[g] && !lt[g];
                assign succ_hit = succ_wrap;
            end else begin : g_mid
                assign first_ge = valid[g] && !lt[g] && lt[g-1];
                assign succ_hit = valid[g] && eq[g-1];
            end
            if (g == MAX_NODES - 1) begin : g_hi
                assign pred_hit = pred_wrap && last[g];
            end else begin : g_nhi
                assign pred_hit = eq[g+1] || (pred_wrap && last[g]);
            end
            assign pick[g] = (is_owner && (first_ge || (g == 0 && owner_wrap)))
                          || (is_succ && succ_hit)
                          || (is_pred && pred_hit);
        end
    endgenerate

    always_comb begin
        picked = '0;
        for (int i = 0; i < MAX_NODES; i++) begin
            picked = picked | pick_id[i];
        end
    end

    // execute: status, row update and answer
    always_comb begin
        n_state   = r_state;
        n_count   = r_count;
        n_valid   = 1'b0;
        n_node_id = '0;
        n_status  = ST_OK;
        do_ins    = 1'b0;
        do_rem    = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = S_IDLE;
                n_valid = 1'b1;
                case (r_op) inside
                    OP_ADD: begin
                        if (member) begin
                            n_status = ST_PRESENT;
                        end else if (full) begin
                            n_status = ST_FULL;
                        end else begin
                            do_ins  = 1'b1;
                            n_count = r_count + CNT_W'(1);
                        end
                    end
                    OP_REM: begin
                        if (!member) begin
                            n_status = ST_NOT_MEMBER;
                        end else begin
                            do_rem  = 1'b1;
                            n_count = r_count - CNT_W'(1);
                        end
                    end
                    OP_OWNER: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else begin
                            n_node_id = picked;
                        end
                    end
                    OP_SUCC, OP_PRED: begin
                        if (empty) begin
                            n_status = ST_EMPTY;
                        end else if (!member) begin
                            n_status = ST_NOT_MEMBER;
                        end else begin
                            n_node_id = picked;
                        end
                    end
                    default: begin
                        // unused codes leave the ring as it is
                    end
                endcase
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // the row of slots
    generate
        for (genvar g = 0; g < MAX_NODES; g++) begin : g_row
            logic            left_lt;
            logic [ID_W-1:0] left_id, right_id;
            if (g == 0) begin : g_lo
                assign left_lt = 1'b1;
                assign left_id = r_key;
            end else begin : g_mid
                assign left_lt = lt[g-1];
                assign left_id = cell_id[g-1];
            end
            if (g == MAX_NODES - 1) begin : g_hi
                assign right_id = cell_id[g];
            end else begin : g_nhi
                assign right_id = cell_id[g+1];
            end

            assign ctl[g].cmp   = accept;
            assign ctl[g].ins   = do_ins;
            assign ctl[g].rem   = do_rem;
            assign ctl[g].pick  = pick[g];
            assign ctl[g].valid = valid[g];

            hrst_cell u_cell (
                .i_clk      (i_clk),
                .i_ctl      (ctl[g]),
                .i_cmp_key  (i_key),
                .i_ins_key  (r_key),
                .i_left_lt  (left_lt),
                .i_left_id  (left_id),
                .i_right_id (right_id),
                .o_id       (cell_id[g]),
                .o_lt       (lt[g]),
                .o_eq       (eq[g]),
                .o_pick_id  (pick_id[g])
            );
        end
    endgenerate

    assign o_valid   = r_valid;
    assign o_node_id = r_node_id;
    assign o_status  = r_status;

endmodule

`default_nettype wire

>>> verif/hash_ring_successor_table_checker.sv
`timescale 1ns / 100ps
// hash_ring_successor_table_checker: tracks the ring membership, predicts each answer, compares
// depends on hrst_pkg; watches the ports of hash_ring_successor_table_top

module hash_ring_successor_table_checker (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           start,
    input  wire                           busy,
    input  wire [hrst_pkg::OP_W-1:0]      i_operation,
    input  wire [hrst_pkg::ID_W-1:0]      i_key,
    input  wire                           o_valid,
    input  wire [hrst_pkg::ID_W-1:0]      o_node_id,
    input  wire [hrst_pkg::ST_W-1:0]      o_status,
    output int                            answers_due,
    output int                            fault_count
);
    import hrst_pkg::*;

    typedef struct {
        logic [ID_W-1:0] node_id;
        t_status         status;
    } t_answer;

    // sorted members, lowest first
    logic [ID_W-1:0] ring_ids [MAX_NODES];
    int              ring_count;

    // answers still to come, oldest first
    t_answer         answer_fifo [4];
    logic [1:0]      wr_ptr;
    logic [1:0]      rd_ptr;
    int              pending;

    function automatic t_answer ring_apply(input logic [OP_W-1:0] op,
                                           input logic [ID_W-1:0] key);
        t_answer ans;
        int      pos;
        bit      hit;
        ans.node_id = '0;
        ans.status  = ST_OK;
        pos = 0;
        while (pos < ring_count && ring_ids[pos] < key) pos++;
        hit = (pos < ring_count) && (ring_ids[pos] == key);
        case (op) inside
            OP_ADD: begin
                if (hit) begin
                    ans.status = ST_PRESENT;
                end else if (ring_count >= MAX_NODES) begin
                    ans.status = ST_FULL;
                end else begin
                    for (int i = ring_count; i > pos; i--) ring_ids[i] = ring_ids[i-1];
                    ring_ids[pos] = key;
                    ring_count++;
                end
            end
            OP_REM: begin
                if (!hit) begin
                    ans.status = ST_NOT_MEMBER;
                end else begin
                    for (int i = pos; i < ring_count - 1; i++) ring_ids[i] = ring_ids[i+1];
                    ring_count--;
                end
            end
            OP_OWNER: begin
                if (ring_count == 0) ans.status = ST_EMPTY;
                else ans.node_id = ring_ids[(pos < ring_count) ? pos : 0];
            end
            OP_SUCC, OP_PRED: begin
                if (ring_count == 0) begin
                    ans.status = ST_EMPTY;
                end else if (!hit) begin
                    ans.status = ST_NOT_MEMBER;
                end else if (op == OP_SUCC) begin
                    ans.node_id = ring_ids[(pos + 1 < ring_count) ? pos + 1 : 0];
                end else begin
                    ans.node_id = ring_ids[(pos == 0) ? ring_count - 1 : pos - 1];
                end
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_answer want;
        if (!i_rst_n) begin
            ring_count = 0;
            wr_ptr     = '0;
            rd_ptr     = '0;
            pending    = 0;
        end else begin
            if (o_valid === 1'b1) begin
                if (pending == 0) begin
                    $error("result with no item outstanding: node_id %h status %0d",
                           o_node_id, o_status);
                    fault_count++;
                end else begin
                    want    = answer_fifo[rd_ptr];
                    rd_ptr  = rd_ptr + 2'd1;
                    pending = pending - 1;
                    if (o_node_id !== want.node_id) begin
                        $error("node_id mismatch: expected %h, got %h",
                               want.node_id, o_node_id);
                        fault_count++;
                    end
                    if (o_status !== want.status) begin
                        $error("status mismatch: expected %0d, got %0d",
                               want.status, o_status);
                        fault_count++;
                    end
                end
            end else if (o_valid !== 1'b0) begin
                $error("o_valid unknown");
                fault_count++;
            end
            if (start && !busy) begin
                answer_fifo[wr_ptr] = ring_apply(i_operation, i_key);
                wr_ptr  = wr_ptr + 2'd1;
                pending = pending + 1;
            end
        end
        answers_due = pending;
    end

endmodule

>>> verif/hash_ring_successor_table_top_test.sv
`timescale 1ns / 100ps
// hash_ring_successor_table_top_test: clock, reset, item stimulus and verdict for the ring table
// depends on hrst_pkg, hash_ring_successor_table_top and hash_ring_successor_table_checker

module hash_ring_successor_table_top_test;
    import hrst_pkg::*;

    localparam int PHASES         = 10;
    localparam int PHASE_ITEMS    = 153;
    localparam int POOL_SIZE      = 80;   // more than the table holds, so adds can hit full
    localparam int WATCHDOG_LIMIT = 500;  // longer than the longest sender gap
    localparam int DRAIN_CYCLES   = 4;

    // opcodes the block must ignore
    localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd5;
    localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

    // operation mix of one random phase
    typedef enum int { MIX_GROW, MIX_EVEN, MIX_SHRINK } t_mix;

    logic            i_clk;
    logic            i_rst_n;
    logic            start;
    logic [OP_W-1:0] i_operation;
    logic [ID_W-1:0] i_key;
    logic            busy;
    logic            o_valid;
    logic [ID_W-1:0] o_node_id;
    logic [ST_W-1:0] o_status;

    int answers_due;
    int fault_count;
    int quiet_cycles;

    // keys are mostly drawn from here so that adds collide and lookups hit members
    logic [ID_W-1:0] key_pool [POOL_SIZE];

    hash_ring_successor_table_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .i_operation (i_operation),
        .i_key       (i_key),
        .busy        (busy),
        .o_valid     (o_valid),
        .o_node_id   (o_node_id),
        .o_status    (o_status)
    );

    hash_ring_successor_table_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_key       (i_key),
        .o_valid     (o_valid),
        .o_node_id   (o_node_id),
        .o_status    (o_status),
        .answers_due (answers_due),
        .fault_count (fault_count)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // watchdog: any accepted item or result restarts the count
    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || o_valid) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("hash_ring_successor_table_top verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // mostly back to back or short gaps, now and then a long one
    function automatic int idle_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // cumulative percentages: add, remove, owner, successor, predecessor, rest ignored
    function automatic logic [OP_W-1:0] pick_op(input t_mix mix);
        int r, add_t, rem_t, own_t, suc_t, pre_t;
        case (mix)
            MIX_GROW: begin
                add_t = 75; rem_t = 80; own_t = 88; suc_t = 93; pre_t = 98;
            end
            MIX_EVEN: begin
                add_t = 30; rem_t = 55; own_t = 73; suc_t = 85; pre_t = 97;
            end
            default: begin
                add_t = 10; rem_t = 65; own_t = 75; suc_t = 84; pre_t = 97;
            end
        endcase
        r = $urandom_range(0, 99);
        if (r < add_t) return OP_ADD;
        if (r < rem_t) return OP_REM;
        if (r < own_t) return OP_OWNER;
        if (r < suc_t) return OP_SUCC;
        if (r < pre_t) return OP_PRED;
        return OP_W'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
    endfunction

    // pool keys, their neighbors (to probe the at-or-after boundary) and free keys
    function automatic logic [ID_W-1:0] pick_key();
        int r, idx;
        r   = $urandom_range(0, 99);
        idx = $urandom_range(0, POOL_SIZE - 1);
        if (r < 60) return key_pool[idx];
        if (r < 75) return key_pool[idx] + 1'b1;
        if (r < 85) return key_pool[idx] - 1'b1;
        return $urandom();
    endfunction

    // present one item, hold it until accepted, then idle for the given gap
    // with junk on the payload while start is low
    task automatic issue(input logic [OP_W-1:0] op, input logic [ID_W-1:0] key,
                         input int gap);
        start       <= 1'b1;
        i_operation <= op;
        i_key       <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) begin
                i_operation <= OP_W'($urandom_range(0, 7));
                i_key       <= $urandom();
                @(posedge i_clk);
            end
        end
    endtask

    initial begin
        t_mix            mix;
        bit              burst;
        int              n;
        logic [OP_W-1:0] op;

        i_rst_n     <= 1'b0;
        start       <= 1'b0;
        i_operation <= OP_ADD;
        i_key       <= '0;

        key_pool[0] = '0;
        key_pool[1] = '1;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom();

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // lookups and a remove on the empty ring
        issue(OP_OWNER, 32'h0000_1234, idle_gap());
        issue(OP_SUCC,  32'h0000_0005, idle_gap());
        issue(OP_PRED,  32'h0000_0005, idle_gap());
        issue(OP_REM,   32'h0000_0005, idle_gap());

        // single member answers itself everywhere, owner wraps to it
        issue(OP_ADD,   32'h8000_0000, idle_gap());
        issue(OP_SUCC,  32'h8000_0000, idle_gap());
        issue(OP_PRED,  32'h8000_0000, idle_gap());
        issue(OP_OWNER, 32'hFFFF_FFFF, idle_gap());

        // duplicate add, successor of a non-member
        issue(OP_ADD,   32'h8000_0000, idle_gap());
        issue(OP_SUCC,  32'h0000_0001, idle_gap());

        // wrap cases with the lowest id on the ring
        issue(OP_ADD,   32'h0000_0000, idle_gap());
        issue(OP_OWNER, 32'h8000_0001, idle_gap());
        issue(OP_SUCC,  32'h8000_0000, idle_gap());
        issue(OP_PRED,  32'h0000_0000, idle_gap());

        // highest id, exact-match and just-below owner lookups
        issue(OP_ADD,   32'hFFFF_FFFF, idle_gap());
        issue(OP_OWNER, 32'hFFFF_FFFF, idle_gap());
        issue(OP_OWNER, 32'h7FFF_FFFF, idle_gap());
        issue(OP_SUCC,  32'hFFFF_FFFF, idle_gap());

        // spare opcodes leave the table alone
        issue(OP_SPARE_LO,        32'hFFFF_FFFF, idle_gap());
        issue(OP_SPARE_LO + 3'd1, 32'h5555_5555, idle_gap());
        issue(OP_SPARE_HI,        32'hAAAA_AAAA, idle_gap());

        // remove, then remove again and look up the gone id
        issue(OP_REM,   32'h8000_0000, idle_gap());
        issue(OP_REM,   32'h8000_0000, idle_gap());
        issue(OP_PRED,  32'h8000_0000, idle_gap());
        issue(OP_PRED,  32'h5555_5555, idle_gap());

        // random phases: grow to full, churn, then drain toward empty
        for (int p = 0; p < PHASES; p++) begin
            if (p % 5 < 2) begin
                mix = MIX_GROW;
            end else if (p % 5 == 2) begin
                mix = MIX_EVEN;
            end else begin
                mix = MIX_SHRINK;
            end
            burst = ($urandom_range(0, 3) == 0);
            n     = 0;
            while (n < PHASE_ITEMS) begin
                op = pick_op(mix);
                issue(op, pick_key(), burst ? 0 : idle_gap());
                if (op <= OP_PRED) n++;
            end
        end

        start <= 1'b0;
        @(posedge i_clk);
        wait (answers_due == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fault_count == 0) begin
            $display("hash_ring_successor_table_top verification clean");
        end else begin
            $display("hash_ring_successor_table_top verification failed");
        end
        $finish;
    end

endmodule

>>> filelist.f
src/hrst_pkg.sv
src/hrst_cell.sv
src/hash_ring_successor_table_top.sv
verif/hash_ring_successor_table_checker.sv
verif/hash_ring_successor_table_top_test.sv
